>>> rtl/core/lctgf_pkg.sv
// ----------------------------------------------------------------------------
// lctgf_pkg: shared definitions for the load-cell tare and glitch filter
// Widths, tare constants, codes, item and result types and back-end states.
// ----------------------------------------------------------------------------
package lctgf_pkg;

    localparam int TARE_COUNT = 16;
    localparam int TARE_IDX_W = (TARE_COUNT > 1) ? $clog2(TARE_COUNT) : 1;
    localparam int TARE_POS_W = $clog2(TARE_COUNT + 1);
    localparam int TARE_CNT_W = TARE_POS_W + 1;
    localparam int MED_IDX    = TARE_COUNT / 2;

    localparam int RAW_W     = 24;
    localparam int VAL_W     = 25;
    localparam int HELD_W    = 26;
    localparam int DELTA_W   = 27;
    localparam int SUM_W     = 32;
    localparam int SC_W      = 7;
    localparam int THR_W     = 25;
    localparam int MAX_SC    = 64;
    localparam int DIV_CNT_W = 5;

    localparam logic KIND_CONV = 1'b0;
    localparam logic KIND_TARE = 1'b1;

    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_SAMPLES   = 1'b1;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(50000);
    localparam logic [SC_W-1:0]  SC_RESET  = SC_W'(1);

    typedef struct packed {
        logic                    kind;
        logic signed [VAL_W-1:0] word;
    } lc_item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] filtered_value;
        logic signed [RAW_W-1:0] zero_offset;
        logic                    tare_done;
        logic                    glitch_pending;
    } lc_result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MEDIAN,
        ST_DIV,
        ST_JUDGE
    } back_state_t;

endpackage

>>> rtl/core/lctgf_front.sv
// ----------------------------------------------------------------------------
// lctgf_front: input acceptance and classification
// Sign-extends each conversion word and queues it with its kind.
// ----------------------------------------------------------------------------
module lctgf_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                in_kind,
    input  logic [lctgf_pkg::RAW_W-1:0]         in_raw,
    output logic                                q_valid,
    input  logic                                q_pop,
    output lctgf_pkg::lc_item_t                 q_item
);

    lctgf_pkg::lc_item_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;
    lctgf_pkg::lc_item_t new_item;

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb begin
        new_item.kind = in_kind;
        new_item.word = {in_raw[lctgf_pkg::RAW_W-1], in_raw};
    end

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

>>> rtl/core/lctgf_back.sv
// ----------------------------------------------------------------------------
// lctgf_back: tare collection, median search, averaging and spike rejection
// Runs one queued item at a time and holds the result until it is taken.
// ----------------------------------------------------------------------------
module lctgf_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_valid,
    output logic                                q_pop,
    input  lctgf_pkg::lc_item_t                 q_item,
    input  logic                                cfg_we,
    input  logic                                cfg_sel,
    input  logic [lctgf_pkg::THR_W-1:0]         cfg_wdata,
    output logic                                res_valid,
    input  logic                                res_ready,
    output lctgf_pkg::lc_result_t               res
);

    localparam int IW = lctgf_pkg::TARE_IDX_W;
    localparam int PW = lctgf_pkg::TARE_POS_W;
    localparam int CW = lctgf_pkg::TARE_CNT_W;

    lctgf_pkg::back_state_t state_reg, state_next;

    logic [lctgf_pkg::THR_W-1:0]          thr_reg;
    logic [lctgf_pkg::SC_W-1:0]           sc_reg;
    logic                                 taring_reg;
    logic [PW-1:0]                        pos_reg;
    logic [PW-1:0]                        cand_reg;
    logic signed [lctgf_pkg::RAW_W-1:0]   buf_reg [lctgf_pkg::TARE_COUNT];
    logic signed [lctgf_pkg::RAW_W-1:0]   offset_reg;
    logic signed [lctgf_pkg::SUM_W-1:0]   sum_reg;
    logic [lctgf_pkg::SC_W-1:0]           cnt_reg;
    logic signed [lctgf_pkg::HELD_W-1:0]  held_reg;
    logic                                 spike_reg;
    logic [lctgf_pkg::SUM_W-1:0]          quo_reg;
    logic [lctgf_pkg::SC_W-1:0]           rem_reg;
    logic [lctgf_pkg::SC_W-1:0]           div_reg;
    logic                                 neg_reg;
    logic [lctgf_pkg::DIV_CNT_W-1:0]      dcnt_reg;
    logic                                 res_valid_reg;
    lctgf_pkg::lc_result_t                res_reg;

    // Derived values
    logic                                 take;
    logic                                 is_tare;
    logic                                 tare_last;
    logic                                 win_done;
    logic [lctgf_pkg::SC_W-1:0]           n_eff;
    logic [lctgf_pkg::SC_W-1:0]           cnt_inc;
    logic signed [lctgf_pkg::HELD_W-1:0]  corrected;
    logic signed [lctgf_pkg::SUM_W-1:0]   sum_new;
    logic [lctgf_pkg::SUM_W-1:0]          sum_mag;
    logic signed [lctgf_pkg::RAW_W-1:0]   cand;
    logic [lctgf_pkg::TARE_COUNT-1:0]     lt_vec;
    logic [lctgf_pkg::TARE_COUNT-1:0]     eq_vec;
    logic [CW-1:0]                        n_lt;
    logic [CW-1:0]                        n_le;
    logic                                 med_hit;
    logic [lctgf_pkg::SC_W:0]             rem_sh;
    logic                                 rem_ge;
    logic [lctgf_pkg::SC_W:0]             rem_sub;
    logic [lctgf_pkg::SUM_W-1:0]          quo_signed;
    logic signed [lctgf_pkg::HELD_W-1:0]  avg;
    logic signed [lctgf_pkg::DELTA_W-1:0] delta;
    logic [lctgf_pkg::DELTA_W-1:0]        delta_abs;
    logic                                 glitch;
    logic signed [lctgf_pkg::HELD_W-1:0]  held_upd;
    logic                                 load_med;
    logic                                 load_avg;

    always_comb begin
        if (sc_reg == '0) begin
            n_eff = lctgf_pkg::SC_W'(1);
        end else if (sc_reg > lctgf_pkg::SC_W'(lctgf_pkg::MAX_SC)) begin
            n_eff = lctgf_pkg::SC_W'(lctgf_pkg::MAX_SC);
        end else begin
            n_eff = sc_reg;
        end
    end

    always_comb begin
        take      = (state_reg == lctgf_pkg::ST_IDLE) && q_valid && !res_valid_reg;
        is_tare   = (q_item.kind == lctgf_pkg::KIND_TARE);
        tare_last = (PW'(pos_reg + 1'b1) >= PW'(lctgf_pkg::TARE_COUNT));
        cnt_inc   = cnt_reg + 1'b1;
        win_done  = (cnt_inc >= n_eff);
        corrected = lctgf_pkg::HELD_W'(q_item.word)
                  - lctgf_pkg::HELD_W'(offset_reg);
        sum_new   = sum_reg + lctgf_pkg::SUM_W'(corrected);
        sum_mag   = sum_new[lctgf_pkg::SUM_W-1] ? (~sum_new + 1'b1) : sum_new;
    end

    // Median search: the candidate is the median once fewer than MED_IDX+1
    // entries sort below it and more than MED_IDX sort at or below it.
    assign cand = buf_reg[cand_reg[IW-1:0]];

    always_comb begin
        for (int i = 0; i < lctgf_pkg::TARE_COUNT; i++) begin
            lt_vec[i] = (buf_reg[i] < cand);
            eq_vec[i] = (buf_reg[i] == cand);
        end
        n_lt    = CW'($countones(lt_vec));
        n_le    = CW'($countones(lt_vec | eq_vec));
        med_hit = (n_lt <= CW'(lctgf_pkg::MED_IDX)) && (n_le > CW'(lctgf_pkg::MED_IDX));
    end

    always_comb begin
        rem_sh  = {rem_reg, quo_reg[lctgf_pkg::SUM_W-1]};
        rem_ge  = (rem_sh >= {1'b0, div_reg});
        rem_sub = rem_sh - {1'b0, div_reg};
    end

    always_comb begin
        quo_signed = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
        avg        = quo_signed[lctgf_pkg::HELD_W-1:0];
        delta      = lctgf_pkg::DELTA_W'(avg) - lctgf_pkg::DELTA_W'(held_reg);
        delta_abs  = delta[lctgf_pkg::DELTA_W-1] ? (~delta + 1'b1) : delta;
        glitch     = (delta_abs > lctgf_pkg::DELTA_W'(thr_reg));
        held_upd   = (!glitch || spike_reg) ? avg : held_reg;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lctgf_pkg::ST_IDLE: begin
                if (take && !is_tare) begin
                    if (taring_reg) begin
                        if (tare_last) begin
                            state_next = lctgf_pkg::ST_MEDIAN;
                        end
                    end else if (win_done) begin
                        state_next = lctgf_pkg::ST_DIV;
                    end
                end
            end
            lctgf_pkg::ST_MEDIAN: begin
                if (med_hit) begin
                    state_next = lctgf_pkg::ST_IDLE;
                end
            end
            lctgf_pkg::ST_DIV: begin
                if (dcnt_reg == '1) begin
                    state_next = lctgf_pkg::ST_JUDGE;
                end
            end
            lctgf_pkg::ST_JUDGE: begin
                state_next = lctgf_pkg::ST_IDLE;
            end
            default: begin
                state_next = lctgf_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs
    always_comb begin
        q_pop    = 1'b0;
        load_med = 1'b0;
        load_avg = 1'b0;
        case (state_reg)
            lctgf_pkg::ST_IDLE:   q_pop    = take;
            lctgf_pkg::ST_MEDIAN: load_med = med_hit;
            lctgf_pkg::ST_JUDGE:  load_avg = 1'b1;
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lctgf_pkg::ST_IDLE;
            thr_reg       <= lctgf_pkg::THR_RESET;
            sc_reg        <= lctgf_pkg::SC_RESET;
            taring_reg    <= 1'b0;
            pos_reg       <= '0;
            offset_reg    <= '0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            held_reg      <= '0;
            spike_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                if (cfg_sel == lctgf_pkg::REG_THRESHOLD) begin
                    thr_reg <= cfg_wdata;
                end else begin
                    sc_reg <= cfg_wdata[lctgf_pkg::SC_W-1:0];
                end
            end
            if (q_pop) begin
                if (is_tare) begin
                    offset_reg <= '0;
                    pos_reg    <= '0;
                    taring_reg <= 1'b1;
                    sum_reg    <= '0;
                    cnt_reg    <= '0;
                end else if (taring_reg) begin
                    pos_reg <= tare_last ? '0 : PW'(pos_reg + 1'b1);
                end else if (win_done) begin
                    sum_reg <= '0;
                    cnt_reg <= '0;
                end else begin
                    sum_reg <= sum_new;
                    cnt_reg <= cnt_inc;
                end
            end
            if (load_med) begin
                offset_reg <= cand;
                taring_reg <= 1'b0;
            end
            if (load_avg) begin
                held_reg  <= held_upd;
                spike_reg <= glitch;
            end
            if (load_med || load_avg) begin
                res_valid_reg <= 1'b1;
            end else if (res_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && !is_tare && taring_reg) begin
            buf_reg[pos_reg[IW-1:0]] <= q_item.word[lctgf_pkg::RAW_W-1:0];
        end
        if (q_pop && !is_tare && taring_reg && tare_last) begin
            cand_reg <= '0;
        end else if (state_reg == lctgf_pkg::ST_MEDIAN) begin
            cand_reg <= PW'(cand_reg + 1'b1);
        end
        if (q_pop && !is_tare && !taring_reg && win_done) begin
            quo_reg  <= sum_mag;
            neg_reg  <= sum_new[lctgf_pkg::SUM_W-1];
            div_reg  <= cnt_inc;
            rem_reg  <= '0;
            dcnt_reg <= '0;
        end else if (state_reg == lctgf_pkg::ST_DIV) begin
            rem_reg  <= rem_ge ? rem_sub[lctgf_pkg::SC_W-1:0] : rem_sh[lctgf_pkg::SC_W-1:0];
            quo_reg  <= {quo_reg[lctgf_pkg::SUM_W-2:0], rem_ge};
            dcnt_reg <= dcnt_reg + 1'b1;
        end
        if (load_med) begin
            res_reg.filtered_value <= held_reg[lctgf_pkg::VAL_W-1:0];
            res_reg.zero_offset    <= cand;
            res_reg.tare_done      <= 1'b1;
            res_reg.glitch_pending <= spike_reg;
        end else if (load_avg) begin
            res_reg.filtered_value <= held_upd[lctgf_pkg::VAL_W-1:0];
            res_reg.zero_offset    <= offset_reg;
            res_reg.tare_done      <= 1'b0;
            res_reg.glitch_pending <= glitch;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_med || load_avg) |-> !res_valid_reg)
        else $error("result register loaded while a result is pending");
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lctgf_pkg::ST_DIV) |-> (div_reg != '0))
        else $error("divider running with a zero divisor");
    a_median_taring: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lctgf_pkg::ST_MEDIAN) |-> taring_reg)
        else $error("median search outside a tare");
    a_busy_no_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != lctgf_pkg::ST_IDLE) |-> !q_pop)
        else $error("item taken while the back end is busy");
`endif

endmodule

>>> rtl/core/load_cell_tare_and_glitch_filter_top.sv
// ----------------------------------------------------------------------------
// load_cell_tare_and_glitch_filter_top: load-cell tare and glitch filter
// Stream front end, two-deep queue and a sequential tare/average back end.
// ----------------------------------------------------------------------------
// A window-closing conversion gives its result after the bit-serial divider
// and the judge state; a tare-ending conversion gives its result after the
// median search (one median candidate per cycle).
// Other items are taken back to back while no result is pending; during the
// divider and the median search the back end takes no new item.
// Reset (aresetn low, synchronous) clears offset, window, held value and
// flags and restores the register defaults; the tare buffer is not cleared.
module load_cell_tare_and_glitch_filter_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [23:0] raw_word
    input  logic        s_tuser,   // [0] kind
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [24:0] filtered_value, [48:25] zero_offset, rest zero
    output logic [1:0]  m_tuser,   // [0] tare_done, [1] glitch_pending
    // Register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [24:0] cfg_data
);

    logic                  q_valid;
    logic                  q_pop;
    lctgf_pkg::lc_item_t   q_item;
    lctgf_pkg::lc_result_t res;

    // Registers are always writable; writes must happen only while idle (not enforced).
    assign cfg_ready = 1'b1;

    lctgf_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_kind  (s_tuser),
        .in_raw   (s_tdata),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    lctgf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .cfg_we    (cfg_valid),
        .cfg_sel   (cfg_index),
        .cfg_wdata (cfg_data),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // The result bus carries the held value and the offset; the flags
    // travel on the user lane.
    assign m_tdata = {7'd0, res.zero_offset, res.filtered_value};
    assign m_tuser = {res.glitch_pending, res.tare_done};

endmodule

>>> dv/tb_load_cell_tare_and_glitch_filter_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_load_cell_tare_and_glitch_filter_top: stream test of the tare/glitch filter
// Drives conversion and tare transactions over several register settings and
// idling phases, predicts every result in a behavioral model of the filter
// and compares each result transaction field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_load_cell_tare_and_glitch_filter_top;

    localparam int  CLK_HALF   = 6;
    localparam int  TARE_N     = lctgf_pkg::TARE_COUNT;
    localparam longint CYCLE_LIMIT = 3000000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [23:0] raw_word
    logic        s_tuser;   // [0] kind
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // [24:0] filtered_value, [48:25] zero_offset, rest zero
    logic [1:0]  m_tuser;   // [0] tare_done, [1] glitch_pending
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [24:0] cfg_data;

    load_cell_tare_and_glitch_filter_top u_dut (.*);

    // Expected result transactions, oldest first.
    typedef struct {
        logic signed [24:0] filtered;
        logic signed [23:0] offset;
        logic               done;
        logic               spike;
    } weigh_result_t;

    weigh_result_t weigh_expected[$];

    // Shadow of the filter state and registers.
    logic [24:0]    thr_reg;
    logic [6:0]     samples_reg;
    bit             in_tare;
    int             tare_pos;
    int             tare_words[TARE_N];
    int             zero_off;
    int             window_sum;
    int             window_cnt;
    int             held;
    bit             spike;

    int  errors = 0;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  recv_hold;
    longint cycles = 0;

    // Sign-extends a 24-bit conversion word.
    function automatic int sext_word(logic [23:0] w);
        return int'(signed'(w));
    endfunction

    // Advances the shadow state by one accepted input transaction and queues
    // the result that it causes, if any.
    task automatic predict_weighing(logic kind, logic [23:0] raw);
        int w;
        int n;
        int avg;
        longint jump;
        int sorted_buf[TARE_N];
        int key;
        int j;
        weigh_result_t r;
        w = sext_word(raw);
        if (kind == lctgf_pkg::KIND_TARE) begin
            zero_off = 0;
            tare_pos = 0;
            in_tare = 1;
            window_sum = 0;
            window_cnt = 0;
            return;
        end
        if (in_tare) begin
            tare_words[tare_pos] = w;
            tare_pos++;
            if (tare_pos >= TARE_N) begin
                sorted_buf = tare_words;
                for (int i = 1; i < TARE_N; i++) begin
                    key = sorted_buf[i];
                    j = i - 1;
                    while (j >= 0 && sorted_buf[j] > key) begin
                        sorted_buf[j + 1] = sorted_buf[j];
                        j--;
                    end
                    sorted_buf[j + 1] = key;
                end
                zero_off = sorted_buf[TARE_N / 2];
                in_tare = 0;
                tare_pos = 0;
                r.filtered = held[24:0];
                r.offset = zero_off[23:0];
                r.done = 1;
                r.spike = spike;
                weigh_expected.push_back(r);
            end
            return;
        end
        n = samples_reg;
        if (n == 0) n = 1;
        if (n > lctgf_pkg::MAX_SC) n = lctgf_pkg::MAX_SC;
        window_sum += w - zero_off;
        window_cnt++;
        if (window_cnt < n) return;
        // SystemVerilog integer division truncates toward zero, as required.
        avg = window_sum / window_cnt;
        window_sum = 0;
        window_cnt = 0;
        jump = longint'(avg) - longint'(held);
        if (jump < 0) jump = -jump;
        if (jump > longint'(thr_reg)) begin
            if (spike) held = avg;
            spike = 1;
        end else begin
            spike = 0;
            held = avg;
        end
        r.filtered = held[24:0];
        r.offset = zero_off[23:0];
        r.done = 0;
        r.spike = spike;
        weigh_expected.push_back(r);
    endtask

    // Clock.
    initial begin
        aclk = 0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Cycle limit.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_load_cell_tare_and_glitch_filter_top: FAIL");
            $finish;
        end
    end

    // Result checker: sampled at the rising edge, compared against the
    // oldest queued expectation.
    always @(posedge aclk) begin
        weigh_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (weigh_expected.size() == 0) begin
                $error("unexpected result transaction tdata=%h tuser=%b", m_tdata, m_tuser);
                errors++;
            end else begin
                e = weigh_expected.pop_front();
                if (m_tdata[24:0] !== e.filtered) begin
                    $error("filtered_value expected %0d actual %0d",
                           e.filtered, signed'(m_tdata[24:0]));
                    errors++;
                end
                if (m_tdata[48:25] !== e.offset) begin
                    $error("zero_offset expected %0d actual %0d",
                           e.offset, signed'(m_tdata[48:25]));
                    errors++;
                end
                if (m_tuser[0] !== e.done) begin
                    $error("tare_done expected %0b actual %0b", e.done, m_tuser[0]);
                    errors++;
                end
                if (m_tuser[1] !== e.spike) begin
                    $error("glitch_pending expected %0b actual %0b", e.spike, m_tuser[1]);
                    errors++;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off while recv_hold is set.
    always @(negedge aclk) begin
        if (!aresetn) m_tready <= 0;
        else if (recv_hold) m_tready <= 0;
        else m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Offers one input transaction, with a random idle gap first, and
    // returns at the falling edge after it has been accepted, with valid
    // still set. Prediction runs on acceptance.
    task automatic send_item(logic kind, logic [23:0] raw);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= kind;
        s_tdata  <= raw;
        do @(posedge aclk); while (!s_tready);
        predict_weighing(kind, raw);
        @(negedge aclk);
    endtask

    // Waits until every expected result has arrived and the back end is
    // quiet. Items with no result may still be in flight, so a margin
    // well beyond the worst latency follows.
    task automatic drain();
        s_tvalid <= 0;
        while (weigh_expected.size() != 0) @(negedge aclk);
        repeat (80) @(negedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [24:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == lctgf_pkg::REG_THRESHOLD) thr_reg = val;
        else samples_reg = val[6:0];
        @(negedge aclk);
        cfg_valid <= 0;
        @(negedge aclk);
    endtask

    // A conversion word that is mostly near a moving base, sometimes a spike,
    // sometimes fully random.
    function automatic logic [23:0] pick_word(int base);
        int r;
        r = $urandom_range(99);
        if (r < 10) return 24'($urandom);
        if (r < 20) return 24'(base + int'($urandom_range(2000000)) - 1000000);
        return 24'(base + int'($urandom_range(4000)) - 2000);
    endfunction

    task automatic random_phase(int count);
        int base;
        base = int'($urandom_range(200000)) - 100000;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 4) begin
                send_item(lctgf_pkg::KIND_TARE, 24'($urandom));
                // Usually a full tare in one run; occasionally break the run off partway.
                for (int k = 0; k < TARE_N; k++) begin
                    if (k > 2 && $urandom_range(99) < 3) break;
                    send_item(lctgf_pkg::KIND_CONV, pick_word(base));
                    i++;
                end
            end else begin
                send_item(lctgf_pkg::KIND_CONV, pick_word(base));
            end
            if ($urandom_range(99) < 2) base = int'($urandom_range(200000)) - 100000;
        end
    endtask

    // Directed rows: kind, raw word, whether an expectation is typed in,
    // and that expectation.
    typedef struct {
        logic        kind;
        logic [23:0] raw;
        bit          typed;
        logic signed [24:0] filtered;
        logic signed [23:0] offset;
        logic        done;
        logic        spike;
    } stim_row_t;

    stim_row_t stim_rows[] = '{
        // Sample count 1 after reset: each conversion closes a window.
        '{lctgf_pkg::KIND_CONV, 24'h000000, 1, 25'sd0, 24'sd0, 0, 0},
        '{lctgf_pkg::KIND_CONV, 24'h00C350, 1, 25'sd50000, 24'sd0, 0, 0},
        '{lctgf_pkg::KIND_CONV, 24'h7FFFFF, 1, 25'sd50000, 24'sd0, 0, 1},
        '{lctgf_pkg::KIND_CONV, 24'h7FFFFF, 1, 25'sd8388607, 24'sd0, 0, 1},
        '{lctgf_pkg::KIND_CONV, 24'h800000, 1, -25'sd8388608, 24'sd0, 0, 1},
        '{lctgf_pkg::KIND_CONV, 24'hFFFFFF, 0, 0, 0, 0, 0},
        '{lctgf_pkg::KIND_TARE, 24'hFFFFFF, 0, 0, 0, 0, 0},
        '{lctgf_pkg::KIND_CONV, 24'h7FFFFF, 0, 0, 0, 0, 0},
        '{lctgf_pkg::KIND_TARE, 24'h000000, 0, 0, 0, 0, 0}
    };

    initial begin
        logic [23:0] w;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        recv_hold = 0;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tuser = 0;
        cfg_valid = 0;
        cfg_index = 0;
        cfg_data = 0;
        thr_reg = lctgf_pkg::THR_RESET;
        samples_reg = lctgf_pkg::SC_RESET;
        in_tare = 0;
        tare_pos = 0;
        zero_off = 0;
        window_sum = 0;
        window_cnt = 0;
        held = 0;
        spike = 0;
        repeat (6) @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);

        // Directed part: extremes, a restarted tare, then a full tare with
        // extreme words so the median lands on a negative value.
        foreach (stim_rows[i]) begin
            weigh_result_t r;
            int before_n;
            before_n = weigh_expected.size();
            send_item(stim_rows[i].kind, stim_rows[i].raw);
            if (stim_rows[i].typed && weigh_expected.size() == before_n + 1) begin
                r = weigh_expected[$];
                if (r.filtered !== stim_rows[i].filtered || r.offset !== stim_rows[i].offset ||
                    r.done !== stim_rows[i].done || r.spike !== stim_rows[i].spike) begin
                    $error("directed row %0d disagrees with the predictor", i);
                    errors++;
                end
            end
        end
        for (int k = 0; k < TARE_N; k++) begin
            w = (k % 2) ? 24'h800000 : 24'h7FFFFF;
            if (k > 12) w = 24'hFFFFF0;
            send_item(lctgf_pkg::KIND_CONV, w);
        end
        send_item(lctgf_pkg::KIND_CONV, 24'h123456);
        drain();

        // Wide window with a tare mid-window, then lower the count mid-window.
        write_reg(lctgf_pkg::REG_SAMPLES, 25'd64);
        write_reg(lctgf_pkg::REG_THRESHOLD, 25'd0);
        for (int k = 0; k < 10; k++) send_item(lctgf_pkg::KIND_CONV, 24'(k * 1000));
        send_item(lctgf_pkg::KIND_TARE, 24'h0);
        for (int k = 0; k < TARE_N; k++) send_item(lctgf_pkg::KIND_CONV, 24'($urandom));
        for (int k = 0; k < 64; k++) send_item(lctgf_pkg::KIND_CONV, 24'h800000);
        for (int k = 0; k < 5; k++) send_item(lctgf_pkg::KIND_CONV, 24'h7FFFFF);
        drain();
        write_reg(lctgf_pkg::REG_SAMPLES, 25'd2);
        send_item(lctgf_pkg::KIND_CONV, 24'h000100);
        drain();
        write_reg(lctgf_pkg::REG_SAMPLES, 25'd0);
        send_item(lctgf_pkg::KIND_CONV, 24'h000200);
        send_item(lctgf_pkg::KIND_CONV, 24'hFFFF00);
        drain();
        write_reg(lctgf_pkg::REG_SAMPLES, 25'h7F);
        write_reg(lctgf_pkg::REG_THRESHOLD, 25'h1FFFFFF);
        for (int k = 0; k < 64; k++) send_item(lctgf_pkg::KIND_CONV, 24'($urandom));
        drain();

        // Random phases across idling patterns and register settings.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            write_reg(lctgf_pkg::REG_THRESHOLD,
                      (ph == 5) ? 25'd0 : 25'($urandom_range(200000)));
            write_reg(lctgf_pkg::REG_SAMPLES,
                      25'((ph < 6) ? $urandom_range(1, 4) : $urandom_range(0, 127)));
            if (ph == 2) begin
                // Long receiver hold-off while the sender keeps offering.
                fork
                    begin
                        recv_hold = 1;
                        repeat (2000) @(negedge aclk);
                        recv_hold = 0;
                    end
                    random_phase(90);
                join
            end else begin
                random_phase(90);
            end
            drain();
        end

        if (errors == 0) begin
            $display("tb_load_cell_tare_and_glitch_filter_top: PASS");
        end else begin
            $display("tb_load_cell_tare_and_glitch_filter_top: FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/lctgf_pkg.sv
rtl/core/lctgf_front.sv
rtl/core/lctgf_back.sv
rtl/core/load_cell_tare_and_glitch_filter_top.sv
dv/tb_load_cell_tare_and_glitch_filter_top.sv
